>>> src/wjd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted Jaccard distance block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package wjd_pkg;

  localparam int unsigned ElemWidth  = 17;
  localparam int unsigned AccWidth   = 29;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned QuoWidth   = FracBits + 1;
  localparam int unsigned DivSteps   = QuoWidth;
  localparam int unsigned StepWidth  = $clog2(DivSteps);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  localparam logic [ElemWidth-1:0] OneQ16   = ElemWidth'(1 << FracBits);
  localparam logic [AccWidth-1:0]  AccLimit = '1;

  // One finished pair of sums waiting for the divider.
  typedef struct packed {
    logic [AccWidth-1:0] min_sum;
    logic [AccWidth-1:0] max_sum;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } back_state_e;

endpackage

>>> src/wjd_front.sv
`timescale 1ns / 1ps
// Front end: orders each element pair and keeps the two saturating sums.
// Depends on wjd_pkg; hands a job to wjd_queue on the pair marked last.
module wjd_front import wjd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [ElemWidth-1:0] elem_a_i,
  input  logic [ElemWidth-1:0] elem_b_i,
  input  logic                 last_i,
  output logic                 push_o,
  output job_t                 job_o
);

  logic [AccWidth-1:0]  min_acc_q, min_acc_d;
  logic [AccWidth-1:0]  max_acc_q, max_acc_d;
  logic [ElemWidth-1:0] lo, hi;
  logic [AccWidth:0]    min_sum, max_sum;
  logic [AccWidth-1:0]  min_new, max_new;

  always_comb begin
    if (elem_a_i < elem_b_i) begin
      lo = elem_a_i;
      hi = elem_b_i;
    end else begin
      lo = elem_b_i;
      hi = elem_a_i;
    end
    min_sum = {1'b0, min_acc_q} + (AccWidth + 1)'(lo);
    max_sum = {1'b0, max_acc_q} + (AccWidth + 1)'(hi);
    min_new = min_sum[AccWidth] ? AccLimit : min_sum[AccWidth-1:0];
    max_new = max_sum[AccWidth] ? AccLimit : max_sum[AccWidth-1:0];

    min_acc_d = min_acc_q;
    max_acc_d = max_acc_q;
    if (accept_i) begin
      // The sums restart from zero once the last pair has been handed on.
      min_acc_d = last_i ? '0 : min_new;
      max_acc_d = last_i ? '0 : max_new;
    end
  end

  assign push_o        = accept_i && last_i;
  assign job_o.min_sum = min_new;
  assign job_o.max_sum = max_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_acc_q <= '0;
      max_acc_q <= '0;
    end else begin
      min_acc_q <= min_acc_d;
      max_acc_q <= max_acc_d;
    end
  end

endmodule

>>> src/wjd_queue.sv
`timescale 1ns / 1ps
// Short job queue between the accumulating front end and the divider.
// Depends on wjd_pkg for the job type and depth.
module wjd_queue import wjd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCntWidth'(QueueDepth));
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> src/wjd_back.sv
`timescale 1ns / 1ps
// Back end: radix-2 restoring divider for min_sum * 2^16 / max_sum, one
// quotient bit per cycle, and the final distance. Depends on wjd_pkg.
module wjd_back import wjd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  job_t                 job_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [ElemWidth-1:0] distance_o,
  output logic                 both_empty_o
);

  back_state_e          state_q, state_d;
  logic [AccWidth-1:0]  rem_q;
  logic [AccWidth-1:0]  div_q;
  logic [QuoWidth-1:0]  quo_q;
  logic [StepWidth-1:0] step_q;
  logic                 empty_q;
  logic                 load, step;
  logic [AccWidth:0]    trial, diff;
  logic                 fits;

  // The first step compares the sum itself, later ones the doubled remainder.
  always_comb begin
    trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    fits  = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    step    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          load    = 1'b1;
          state_d = (job_i.max_sum == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        step = 1'b1;
        if (step_q == StepWidth'(DivSteps - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= job_i.min_sum;
      div_q   <= job_i.max_sum;
      quo_q   <= '0;
      step_q  <= '0;
      empty_q <= (job_i.max_sum == '0);
    end else if (step) begin
      rem_q  <= fits ? diff[AccWidth-1:0] : trial[AccWidth-1:0];
      quo_q  <= {quo_q[QuoWidth-2:0], fits};
      step_q <= step_q + 1'b1;
    end
  end

  assign pop_o          = load;
  assign result_valid_o = (state_q == ST_DONE);
  assign distance_o     = empty_q ? OneQ16 : ElemWidth'(OneQ16 - quo_q);
  assign both_empty_o   = empty_q;

endmodule

>>> src/weighted_jaccard_distance.sv
`timescale 1ns / 1ps
// Weighted Jaccard distance over streamed element pairs; uses wjd_pkg.
// Throughput: one pair per cycle while busy is low; busy rises only when two
// finished sketches wait in the job queue. The accepted last pair pushes its job;
// a free divider loads it, runs its 17-step one-bit-per-cycle division and shows
// the result in its done state; an empty sketch skips the division entirely.
// Reset (rst_ni low, asynchronous) clears the sums, empties the queue and idles the divider.
module weighted_jaccard_distance import wjd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ElemWidth-1:0] elem_a_i,
  input  logic [ElemWidth-1:0] elem_b_i,
  input  logic                 last_i,
  output logic                 result_valid_o,
  output logic [ElemWidth-1:0] distance_o,
  output logic                 both_empty_o
);

  logic accept;
  logic push, pop, job_valid, full;
  job_t front_job, queue_job;

  assign busy   = full;
  assign accept = start && !full;

  wjd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .elem_a_i (elem_a_i),
    .elem_b_i (elem_b_i),
    .last_i   (last_i),
    .push_o   (push),
    .job_o    (front_job)
  );

  wjd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .valid_o (job_valid),
    .full_o  (full),
    .job_o   (queue_job)
  );

  wjd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (queue_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .distance_o     (distance_o),
    .both_empty_o   (both_empty_o)
  );

endmodule
